>>> rtl/printer_escape_sequence_parser_top_defines.svh
// assertion macros shared by the parser modules
`ifndef PRINTER_ESCAPE_SEQUENCE_PARSER_TOP_DEFINES_SVH
`define PRINTER_ESCAPE_SEQUENCE_PARSER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PESP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pesp assertion failed");

// next-cycle implication, checked outside reset
`define PESP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pesp assertion failed");

`endif

>>> rtl/pesp_pkg.sv
// shared types and constants of the escape sequence parser
`timescale 1ns / 1ps
package pesp_pkg;

    localparam logic [7:0] ESC_BYTE     = 8'h1B;
    localparam logic [7:0] CODE_LPI8    = 8'h30;
    localparam logic [7:0] CODE_SP14    = 8'h31;
    localparam logic [7:0] CODE_LPI6    = 8'h32;
    localparam logic [7:0] CODE_ARG_A   = 8'h41;
    localparam logic [7:0] CODE_GFX_L   = 8'h4C;
    localparam logic [7:0] ARG_MAX      = 8'd85;
    localparam logic [7:0] LPI_EIGHT    = 8'd8;
    localparam logic [7:0] LPI_SIX      = 8'd6;
    localparam logic [7:0] SPACING_14   = 8'd14;
    localparam logic [7:0] GFX_DPI      = 8'd120;
    localparam logic [6:0] PIN_MASK     = 7'h7F;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        CMD_OTHER  = 3'd0,
        CMD_LPI8   = 3'd1,
        CMD_SP14   = 3'd2,
        CMD_LPI6   = 3'd3,
        CMD_ARG_A  = 3'd4,
        CMD_GFX_L  = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_CHAR    = 3'd1,
        EV_LPI     = 3'd2,
        EV_SPACING = 3'd3,
        EV_GFX     = 3'd4,
        EV_PLOT    = 3'd5
    } t_event_kind;

    typedef enum logic [3:0] {
        MODE_TEXT = 4'b0001,
        MODE_CODE = 4'b0010,
        MODE_ARG  = 4'b0100,
        MODE_DATA = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [7:0] data;
        logic       is_esc;
        t_cmd       cmd;
    } t_rx_class;

endpackage

>>> rtl/printer_escape_sequence_parser_top.sv
// top level of the printer escape sequence parser
`timescale 1ns / 1ps
// Parses a dot-matrix escape code byte stream and returns exactly one event per
// byte, in order. Bytes are classified on entry, held in a two-entry queue and
// parsed by a state machine feeding a registered output, so a new byte is taken
// every cycle while the output is drained. An accepted byte is registered in the
// queue and then in the output register. The sustained rate of one byte per cycle
// holds while the output is drained, as the back-end parser updates once per byte.
module printer_escape_sequence_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_event_kind,
    output logic [7:0]  o_event_value,
    output logic        o_graphics_end
);
    import pesp_pkg::*;

    logic       w_q_full;
    logic       w_q_push;
    t_rx_class  w_push_class;
    logic       w_q_valid;
    logic       w_q_pop;
    t_rx_class  w_pop_class;

    pesp_front u_front (
        .i_rx_valid (i_valid),
        .i_rx_byte  (i_rx_byte),
        .o_rx_ready (o_ready),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_class  (w_push_class)
    );

    pesp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_push_class),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_pop_class)
    );

    pesp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_q_data       (w_pop_class),
        .o_q_pop        (w_q_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_event_kind   (o_event_kind),
        .o_event_value  (o_event_value),
        .o_graphics_end (o_graphics_end)
    );

endmodule

>>> rtl/pesp_front.sv
// front end: accepts host bytes and classifies them for the queue
`timescale 1ns / 1ps
module pesp_front (
    input  logic                 i_rx_valid,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_rx_ready,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output pesp_pkg::t_rx_class  o_q_class
);
    import pesp_pkg::*;

    t_cmd w_cmd;

    always_comb begin
        case (i_rx_byte)
            CODE_LPI8:  w_cmd = CMD_LPI8;
            CODE_SP14:  w_cmd = CMD_SP14;
            CODE_LPI6:  w_cmd = CMD_LPI6;
            CODE_ARG_A: w_cmd = CMD_ARG_A;
            CODE_GFX_L: w_cmd = CMD_GFX_L;
            default:    w_cmd = CMD_OTHER;
        endcase
    end

    assign o_rx_ready       = !i_q_full;
    assign o_q_push         = i_rx_valid && !i_q_full;
    assign o_q_class.data   = i_rx_byte;
    assign o_q_class.is_esc = (i_rx_byte == ESC_BYTE);
    assign o_q_class.cmd    = w_cmd;

endmodule

>>> rtl/pesp_queue.sv
// short queue of classified bytes between front and back
`timescale 1ns / 1ps
`include "printer_escape_sequence_parser_top_defines.svh"
module pesp_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  pesp_pkg::t_rx_class  i_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output pesp_pkg::t_rx_class  o_data
);
    import pesp_pkg::*;

    t_rx_class             r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count;
    logic [QUEUE_AW-1:0]   n_wr_ptr;
    logic [QUEUE_AW-1:0]   n_rd_ptr;
    logic [QUEUE_CW-1:0]   n_count;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `PESP_ASSERT_SAME(a_count_bound, 1'b1, r_count <= QUEUE_CW'(QUEUE_DEPTH))
    `PESP_ASSERT_NEXT(a_fill_to_full, i_push && !i_pop && r_count == QUEUE_CW'(QUEUE_DEPTH - 1), o_full)
    `PESP_ASSERT_SAME(a_no_push_full, o_full, !i_push)

endmodule

>>> rtl/pesp_back.sv
// back end: escape sequence state machine and result register
`timescale 1ns / 1ps
`include "printer_escape_sequence_parser_top_defines.svh"
module pesp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  pesp_pkg::t_rx_class  i_q_data,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [2:0]           o_event_kind,
    output logic [7:0]           o_event_value,
    output logic                 o_graphics_end
);
    import pesp_pkg::*;

    t_mode        r_mode;
    t_mode        n_mode;
    logic [7:0]   r_command_code;
    logic [7:0]   n_command_code;
    logic [15:0]  r_argument_value;
    logic [15:0]  n_argument_value;
    logic [1:0]   r_arg_expected;
    logic [1:0]   n_arg_expected;
    logic [1:0]   r_arg_seen;
    logic [1:0]   n_arg_seen;
    logic [15:0]  r_data_expected;
    logic [15:0]  n_data_expected;
    logic [15:0]  r_data_seen;
    logic [15:0]  n_data_seen;
    logic         r_out_valid;
    t_event_kind  r_kind;
    logic [7:0]   r_value;
    logic         r_gend;
    t_event_kind  n_kind;
    logic [7:0]   n_value;
    logic         n_gend;
    logic [15:0]  w_arg_merged;
    logic [7:0]   w_arg_clamped;
    logic         w_pop;

    assign w_pop   = i_q_valid && (!r_out_valid || i_ready);
    assign o_q_pop = w_pop;

    assign w_arg_merged  = r_arg_seen[0] ? (r_argument_value | {i_q_data.data, 8'h00})
                                         : (r_argument_value | {8'h00, i_q_data.data});
    assign w_arg_clamped = (w_arg_merged > {8'h00, ARG_MAX}) ? ARG_MAX : w_arg_merged[7:0];

    always_comb begin
        n_mode           = r_mode;
        n_command_code   = r_command_code;
        n_argument_value = r_argument_value;
        n_arg_expected   = r_arg_expected;
        n_arg_seen       = r_arg_seen;
        n_data_expected  = r_data_expected;
        n_data_seen      = r_data_seen;
        n_kind           = EV_NONE;
        n_value          = '0;
        n_gend           = 1'b0;
        case (r_mode)
            MODE_TEXT: begin
                if (i_q_data.is_esc) begin
                    n_mode = MODE_CODE;
                end else begin
                    n_kind  = EV_CHAR;
                    n_value = i_q_data.data;
                end
            end
            MODE_CODE: begin
                n_command_code = i_q_data.data;
                case (i_q_data.cmd)
                    CMD_LPI8: begin
                        n_kind  = EV_LPI;
                        n_value = LPI_EIGHT;
                        n_mode  = MODE_TEXT;
                    end
                    CMD_SP14: begin
                        n_kind  = EV_SPACING;
                        n_value = SPACING_14;
                        n_mode  = MODE_TEXT;
                    end
                    CMD_LPI6: begin
                        n_kind  = EV_LPI;
                        n_value = LPI_SIX;
                        n_mode  = MODE_TEXT;
                    end
                    CMD_ARG_A: begin
                        n_mode           = MODE_ARG;
                        n_argument_value = '0;
                        n_arg_expected   = 2'd1;
                        n_arg_seen       = '0;
                    end
                    CMD_GFX_L: begin
                        n_kind           = EV_GFX;
                        n_value          = GFX_DPI;
                        n_mode           = MODE_ARG;
                        n_argument_value = '0;
                        n_arg_expected   = 2'd2;
                        n_arg_seen       = '0;
                    end
                    default: begin
                        n_mode = MODE_CODE;
                    end
                endcase
            end
            MODE_ARG: begin
                n_argument_value = w_arg_merged;
                n_arg_seen       = r_arg_seen + 2'd1;
                if (n_arg_seen >= r_arg_expected) begin
                    if (r_command_code == CODE_ARG_A) begin
                        n_argument_value = {8'h00, w_arg_clamped};
                        n_kind           = EV_SPACING;
                        n_value          = {w_arg_clamped[6:0], 1'b0};
                        n_mode           = MODE_TEXT;
                    end else if (r_command_code == CODE_GFX_L) begin
                        n_mode          = MODE_DATA;
                        n_data_expected = w_arg_merged;
                        n_data_seen     = '0;
                    end else begin
                        n_mode = MODE_TEXT;
                    end
                end
            end
            MODE_DATA: begin
                if (r_command_code == CODE_GFX_L) begin
                    n_kind      = EV_PLOT;
                    n_value     = {1'b0, i_q_data.data[6:0] & PIN_MASK};
                    n_data_seen = (r_data_seen != 16'hFFFF) ? r_data_seen + 16'd1 : r_data_seen;
                    if (n_data_seen >= r_data_expected) begin
                        n_mode = MODE_TEXT;
                        n_gend = 1'b1;
                    end
                end else begin
                    n_mode = MODE_TEXT;
                end
            end
            default: begin
                n_mode = MODE_TEXT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode           <= MODE_TEXT;
            r_command_code   <= '0;
            r_argument_value <= '0;
            r_arg_expected   <= '0;
            r_arg_seen       <= '0;
            r_data_expected  <= '0;
            r_data_seen      <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (w_pop) begin
                r_mode           <= n_mode;
                r_command_code   <= n_command_code;
                r_argument_value <= n_argument_value;
                r_arg_expected   <= n_arg_expected;
                r_arg_seen       <= n_arg_seen;
                r_data_expected  <= n_data_expected;
                r_data_seen      <= n_data_seen;
                r_out_valid      <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_kind  <= n_kind;
            r_value <= n_value;
            r_gend  <= n_gend;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_event_kind   = r_kind;
    assign o_event_value  = r_value;
    assign o_graphics_end = r_gend;

    `PESP_ASSERT_SAME(a_gend_on_plot, r_out_valid && r_gend, r_kind == EV_PLOT)
    `PESP_ASSERT_SAME(a_none_zero, r_out_valid && r_kind == EV_NONE, r_value == 8'h00)
    `PESP_ASSERT_NEXT(a_gend_to_text, w_pop && n_gend, r_mode == MODE_TEXT)

endmodule
